@@ rtl/core/lstt_pkg.sv @@
// shared types and constants for the load/store transaction table
package lstt_pkg;

  localparam int LOAD_PORTS_DEF    = 6;
  localparam int STORE_PORTS_DEF   = 1;
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int ADDR_WIDTH_DEF    = 32;

  typedef enum logic [1:0] {
    OP_REQ  = 2'd0,
    OP_TICK = 2'd1,
    OP_RDN  = 2'd2,
    OP_WRDN = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    K_IDLE   = 4'd0,
    K_LDONE  = 4'd1,
    K_SDONE  = 4'd2,
    K_HIT    = 4'd3,
    K_MISS   = 4'd4,
    K_BUSY   = 4'd5,
    K_ACK    = 4'd6,
    K_NOMAT  = 4'd7,
    K_MATCH  = 4'd8,
    K_MULTI  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RPT,
    S_ISSUE,
    S_ADMIT,
    S_MEM,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  port;
    logic [31:0] addr;
    logic        request_valid;
    logic [15:0] cache_latency;
    logic        cache_hit;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  port_res;
    logic [31:0] addr_res;
    logic [2:0]  entry;
    logic [31:0] cycle;
    logic        last;
  } out_word_t;

endpackage

@@ rtl/core/load_store_transaction_table.sv @@
// load/store transaction table: port buffers, entry table and tick sequencer
// word sequence: a port request is stored and finishes; a memory done event scans all
//   entries; a tick runs the report scan, the issue scan and round-robin admission
//   (one entry or port per cycle, admission stops at the first pending port)
// throughput: one word at a time; busy drops in the cycle the last result is shown
// reset (rst, synchronous): all ports and entries empty, tick count and pointer zero
module load_store_transaction_table
  import lstt_pkg::*;
#(
  parameter int LOAD_PORTS    = LOAD_PORTS_DEF,
  parameter int STORE_PORTS   = STORE_PORTS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ADDR_WIDTH    = ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  din,
  output logic      busy,
  output logic      res_valid,
  output out_word_t res
);

  localparam int NPORTS = LOAD_PORTS + STORE_PORTS;
  localparam int PW = (NPORTS > 1) ? $clog2(NPORTS) : 1;
  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int PCW = $clog2(NPORTS + 1);
  localparam int ECW = $clog2(TABLE_ENTRIES + 1);

  // port buffers
  logic [NPORTS-1:0]     port_pending;
  logic [ADDR_WIDTH-1:0] port_address [NPORTS];
  logic [PW-1:0]         rr_pointer;

  // entry table
  logic [TABLE_ENTRIES-1:0] entry_valid, entry_is_write, entry_issued, entry_done;
  logic [ADDR_WIDTH-1:0]    entry_address [TABLE_ENTRIES];
  logic [PW-1:0]            entry_port    [TABLE_ENTRIES];
  logic [15:0]              entry_age     [TABLE_ENTRIES];
  logic [15:0]              entry_latency [TABLE_ENTRIES];
  logic [15:0]              entry_wait    [TABLE_ENTRIES];
  logic [31:0]              tick_count;

  // sequencer
  state_t         state, state_next;
  in_word_t       cur;
  logic [ECW-1:0] idx;    // shared scan index for entries
  logic [PCW-1:0] pk;     // port scan step
  logic           pick_ok;
  logic [EW-1:0]  pick;
  logic [15:0]    best;
  logic           any_out;
  logic [1:0]     mcount;
  logic [EW-1:0]  mfirst;

  logic [EW-1:0] ie;
  assign ie = idx[EW-1:0];

  // current port in the round-robin scan
  logic [PCW:0]  psum;
  logic [PW-1:0] pcur;
  assign psum = (PCW+1)'(rr_pointer) + (PCW+1)'(pk);
  assign pcur = (psum >= (PCW+1)'(NPORTS)) ? PW'(psum - (PCW+1)'(NPORTS)) : PW'(psum);

  // lowest free entry
  logic          free_ok;
  logic [EW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_ok  = 1'b1;
        free_idx = EW'(i);
      end
    end
  end

  // entry match for memory done
  logic mhit;
  assign mhit = entry_valid[ie] && entry_issued[ie] && !entry_done[ie] &&
                (entry_is_write[ie] == (cur.opcode == OP_WRDN)) &&
                (entry_address[ie] == ADDR_WIDTH'(cur.addr));

  logic last_e;
  assign last_e = (idx == ECW'(TABLE_ENTRIES - 1));

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) begin
        unique case (op_t'(din.opcode))
          OP_REQ:  state_next = S_FIN;
          OP_TICK: state_next = S_RPT;
          default: state_next = S_MEM;
        endcase
      end
      S_RPT:   if (last_e) state_next = S_ISSUE;
      S_ISSUE: if (last_e) state_next = S_ADMIT;
      S_ADMIT: if (port_pending[pcur] || pk == PCW'(NPORTS - 1)) state_next = S_FIN;
      S_MEM:   if (last_e) state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result build: combinational word plus strobe
  out_word_t ow;
  logic      ov;
  always_comb begin
    ov = 1'b0;
    ow = '0;
    ow.cycle = tick_count;
    unique case (state)
      S_RPT: if (entry_valid[ie] && entry_done[ie] && entry_wait[ie] >= entry_latency[ie]) begin
        ov = 1'b1;
        ow.kind = entry_is_write[ie] ? K_SDONE : K_LDONE;
        ow.port_res = 3'(entry_port[ie]);
        ow.addr_res = 32'(entry_address[ie]);
        ow.entry = 3'(ie);
      end
      S_ADMIT: if (port_pending[pcur] && free_ok) begin
        ov = 1'b1;
        ow.kind = K_ACK;
        ow.port_res = 3'(pcur);
        ow.addr_res = 32'(port_address[pcur]);
        ow.entry = 3'(free_idx);
      end
      S_FIN: if (cur.opcode == OP_RDN || cur.opcode == OP_WRDN) begin
        ov = 1'b1;
        ow.addr_res = cur.addr;
        if (mcount == 2'd0) ow.kind = K_NOMAT;
        else begin
          ow.kind = (mcount == 2'd1) ? K_MATCH : K_MULTI;
          ow.port_res = 3'(entry_port[mfirst]);
          ow.entry = 3'(mfirst);
        end
      end else if (!any_out) begin
        ov = 1'b1;
      end
      default: ;
    endcase
  end

  // issue result comes at the end of the issue scan
  logic iv;
  always_comb iv = (state == S_ISSUE) && last_e && (pick_ok || (entry_valid[ie] &&
                    !entry_issued[ie]));
  logic          ipk_ok;
  logic [EW-1:0] ipk;
  always_comb begin
    ipk_ok = pick_ok;
    ipk    = pick;
    if (state == S_ISSUE && entry_valid[ie] && !entry_issued[ie] &&
        (!pick_ok || entry_age[ie] > best)) begin
      ipk_ok = 1'b1;
      ipk    = ie;
    end
  end

  // issue word: busy cache, hit or miss
  out_word_t iw;
  always_comb begin
    iw = '0;
    iw.cycle = tick_count;
    iw.port_res = 3'(entry_port[ipk]);
    iw.addr_res = 32'(entry_address[ipk]);
    iw.entry = 3'(ipk);
    if (cur.cache_latency == 16'd0) iw.kind = K_BUSY;
    else if (cur.cache_hit) iw.kind = K_HIT;
    else iw.kind = K_MISS;
  end

  // a pending output is held back so "last" is known
  out_word_t hold, hold_next, res_next;
  logic      hold_v, hold_v_next, res_valid_next, any_out_next;

  // emit the held word when a newer one arrives, or with last at finish
  always_comb begin
    hold_next      = hold;
    hold_v_next    = hold_v;
    res_next       = res;
    res_valid_next = 1'b0;
    any_out_next   = any_out;
    if (state == S_IDLE && start) any_out_next = 1'b0;
    if (ov || iv) begin
      if (hold_v) begin
        res_next       = hold;
        res_valid_next = 1'b1;
      end
      hold_next    = iv ? iw : ow;
      hold_v_next  = 1'b1;
      any_out_next = 1'b1;
    end
    if (state == S_FIN) begin
      res_next       = ov ? ow : hold;
      res_next.last  = 1'b1;
      res_valid_next = 1'b1;
      hold_v_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      port_pending <= '0;
      rr_pointer <= '0;
      entry_valid <= '0;
      entry_issued <= '0;
      entry_done <= '0;
      entry_is_write <= '0;
      tick_count <= '0;
      hold_v <= 1'b0;
      res_valid <= 1'b0;
      idx <= '0;
      pk <= '0;
      pick_ok <= 1'b0;
      any_out <= 1'b0;
      mcount <= '0;
    end else begin
      state <= state_next;
      res <= res_next;
      res_valid <= res_valid_next;
      hold <= hold_next;
      hold_v <= hold_v_next;
      any_out <= any_out_next;

      unique case (state)
        S_IDLE: if (start) begin
          cur <= din;
          idx <= '0;
          pk <= '0;
          pick_ok <= 1'b0;
          best <= '0;
          mcount <= '0;
          mfirst <= '0;
          if (din.opcode == OP_TICK) tick_count <= tick_count + 32'd1;
          if (din.opcode == OP_REQ && {1'b0, din.port} < 4'(NPORTS)) begin
            port_pending[PW'(din.port)] <= din.request_valid;
            port_address[PW'(din.port)] <= ADDR_WIDTH'(din.addr);
          end
        end
        S_RPT: begin
          idx <= last_e ? '0 : idx + ECW'(1);
          if (entry_valid[ie] && entry_done[ie]) begin
            if (entry_wait[ie] >= entry_latency[ie]) begin
              entry_valid[ie] <= 1'b0;
              entry_issued[ie] <= 1'b0;
              entry_done[ie] <= 1'b0;
            end else begin
              entry_wait[ie] <= entry_wait[ie] + 16'd1;
            end
          end
        end
        S_ISSUE: begin
          idx <= last_e ? '0 : idx + ECW'(1);
          if (entry_valid[ie] && !entry_issued[ie]) begin
            if (!pick_ok || entry_age[ie] > best) begin
              pick_ok <= 1'b1;
              pick <= ie;
              best <= entry_age[ie];
            end
            if (entry_age[ie] != 16'hFFFF) entry_age[ie] <= entry_age[ie] + 16'd1;
          end
          if (last_e && ipk_ok) begin
            entry_latency[ipk] <= cur.cache_latency;
            if (cur.cache_latency != 16'd0) begin
              entry_issued[ipk] <= 1'b1;
              if (cur.cache_hit) begin
                entry_done[ipk] <= 1'b1;
                entry_wait[ipk] <= '0;
              end
            end
          end
        end
        S_ADMIT: begin
          pk <= pk + PCW'(1);
          if (port_pending[pcur]) begin
            if (free_ok) begin
              entry_valid[free_idx] <= 1'b1;
              entry_issued[free_idx] <= 1'b0;
              entry_done[free_idx] <= 1'b0;
              entry_address[free_idx] <= port_address[pcur];
              entry_is_write[free_idx] <= ({1'b0, pcur} >= (PW+1)'(LOAD_PORTS));
              entry_port[free_idx] <= pcur;
              entry_age[free_idx] <= '0;
              entry_latency[free_idx] <= '0;
              entry_wait[free_idx] <= '0;
              port_pending[pcur] <= 1'b0;
              rr_pointer <= (pcur == PW'(NPORTS - 1)) ? '0 : pcur + PW'(1);
            end else begin
              rr_pointer <= pcur;
            end
          end
        end
        S_MEM: begin
          idx <= last_e ? '0 : idx + ECW'(1);
          if (mhit) begin
            entry_done[ie] <= 1'b1;
            entry_wait[ie] <= '0;
            if (mcount == 2'd0) mfirst <= ie;
            if (mcount != 2'd2) mcount <= mcount + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result strobe never fires while idle except for the final word
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !$past(state == S_FIN)) |-> !res_valid)
    else $error("result outside a transaction");
  // the finish cycle always delivers a last word
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (res_valid && res.last))
    else $error("missing last word");
  // tick count only moves on accepting a tick
  a_tick: assert property (@(posedge clk) disable iff (rst)
    (tick_count != $past(tick_count)) |-> $past(state == S_IDLE && start && din.opcode == OP_TICK))
    else $error("tick count moved unexpectedly");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the load/store transaction table
module tb_top;
  import lstt_pkg::*;

  localparam int NPORTS = 7;
  localparam int NENT = 8;
  localparam int NLOAD = 6;
  localparam int WDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic start = 1'b0;
  in_word_t din = '0;
  logic busy;
  logic res_valid;
  out_word_t res;

  load_store_transaction_table uut (
    .clk(clk), .rst(rst), .start(start), .din(din),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state, mirrors the table
  logic        pend_q[NPORTS];
  logic [31:0] paddr_q[NPORTS];
  int          rr_q;
  logic        ev[NENT];
  logic [31:0] ea[NENT];
  logic        ew[NENT];
  logic [2:0]  ep[NENT];
  int          eage[NENT];
  logic        eiss[NENT];
  logic        edone[NENT];
  int          elat[NENT];
  int          ewait[NENT];
  logic [31:0] ticks;

  out_word_t expected_q[$];   // results still owed by the block
  in_word_t  pending_words[$]; // words waiting for the driver
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  logic hold_for_drain = 1'b0;
  logic taken = 1'b0;          // the driven word was accepted at the last edge

  function automatic void clear_ent(int i);
    ev[i] = 0; ea[i] = 0; ew[i] = 0; ep[i] = 0; eage[i] = 0;
    eiss[i] = 0; edone[i] = 0; elat[i] = 0; ewait[i] = 0;
  endfunction

  function automatic void push_result(kind_t k, logic [2:0] p, logic [31:0] a,
                                      logic [2:0] e);
    out_word_t r;
    r.kind = k; r.port_res = p; r.addr_res = a; r.entry = e;
    r.cycle = ticks; r.last = 1'b0;
    expected_q = {expected_q, r};
  endfunction

  function automatic void queue_word(in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NPORTS; i++) begin
      pend_q[i] = 0; paddr_q[i] = 0;
    end
    for (int i = 0; i < NENT; i++) clear_ent(i);
    rr_q = 0;
    ticks = 0;
  endfunction

  // work out all results of one accepted word
  function automatic void predict_word(in_word_t w);
    int n0;
    int pick;
    int best;
    int found;
    int cnt;
    int first;
    logic wr;
    n0 = expected_q.size();
    pick = -1; best = 0; found = -1; cnt = 0; first = 0;
    case (op_t'(w.opcode))
      OP_REQ: begin
        if (w.port < NPORTS) begin
          pend_q[w.port] = w.request_valid;
          paddr_q[w.port] = w.addr;
        end
      end
      OP_TICK: begin
        ticks = ticks + 32'd1;
        // report and free finished entries
        for (int i = 0; i < NENT; i++) begin
          if (ev[i] && edone[i]) begin
            if (ewait[i] >= elat[i]) begin
              push_result(ew[i] ? K_SDONE : K_LDONE, ep[i], ea[i], 3'(i));
              clear_ent(i);
            end else begin
              ewait[i]++;
            end
          end
        end
        // oldest unissued entry goes to the cache
        for (int i = 0; i < NENT; i++) begin
          if (ev[i] && !eiss[i]) begin
            if (pick < 0 || eage[i] > best) begin
              best = eage[i]; pick = i;
            end
            if (eage[i] < 65535) eage[i]++;
          end
        end
        if (pick >= 0) begin
          elat[pick] = int'(w.cache_latency);
          if (w.cache_latency == 16'd0) begin
            push_result(K_BUSY, ep[pick], ea[pick], 3'(pick));
          end else begin
            eiss[pick] = 1;
            if (w.cache_hit) begin
              edone[pick] = 1; ewait[pick] = 0;
              push_result(K_HIT, ep[pick], ea[pick], 3'(pick));
            end else begin
              push_result(K_MISS, ep[pick], ea[pick], 3'(pick));
            end
          end
        end
        // round-robin admission of one pending port
        for (int k = 0; k < NPORTS; k++) begin
          if (found < 0 && pend_q[(rr_q + k) % NPORTS]) found = (rr_q + k) % NPORTS;
        end
        if (found >= 0) begin
          rr_q = found;
          for (int i = 0; i < NENT; i++) begin
            if (!ev[i] && rr_q == found && pend_q[found]) begin
              clear_ent(i);
              ev[i] = 1; ea[i] = paddr_q[found]; ew[i] = (found >= NLOAD);
              ep[i] = 3'(found); pend_q[found] = 0;
              push_result(K_ACK, 3'(found), ea[i], 3'(i));
              rr_q = (found + 1) % NPORTS;
            end
          end
        end
      end
      default: begin
        wr = (op_t'(w.opcode) == OP_WRDN);
        for (int i = 0; i < NENT; i++) begin
          if (ev[i] && eiss[i] && !edone[i] && ew[i] == wr && ea[i] == w.addr) begin
            edone[i] = 1; ewait[i] = 0;
            if (cnt == 0) first = i;
            cnt++;
          end
        end
        if (cnt == 0) push_result(K_NOMAT, 3'd0, w.addr, 3'd0);
        else push_result(cnt == 1 ? K_MATCH : K_MULTI, ep[first], w.addr, 3'(first));
      end
    endcase
    if (expected_q.size() == n0) push_result(K_IDLE, 3'd0, 32'd0, 3'd0);
    expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function automatic in_word_t make_word(op_t op, int p, logic [31:0] a, logic v,
                                         logic [15:0] lat, logic h);
    in_word_t w;
    w.opcode = op; w.port = 3'(p); w.addr = a; w.request_valid = v;
    w.cache_latency = lat; w.cache_hit = h;
    return w;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // driver: inputs change on the falling edge
  int gap_cnt = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // word still waiting for acceptance
    end else if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      start <= 1'b0;
    end else if (hold_for_drain && expected_q.size() != 0) begin
      start <= 1'b0;
    end else if (pending_words.size() != 0) begin
      din <= pending_words.pop_front();
      start <= 1'b1;
      gap_cnt <= gap_len();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: sample on the rising edge, predict accepted words and check results
  int idle_cycles = 0;
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (res_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (res_valid) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, res);
          errors <= errors + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (res !== exp_w) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, res);
            errors <= errors + 1;
          end
        end
      end
      // accept after checking so a result from this word never overlaps its own prediction
      if (start && !busy) begin
        words_sent <= words_sent + 1;
        predict_word(din);
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // stimulus
  logic [31:0] hot_addr[4];
  initial begin
    in_word_t w;
    int op;
    rst = 1'b1;
    table_reset();
    hot_addr[0] = 32'h0000_0000; hot_addr[1] = 32'hFFFF_FFFF;
    hot_addr[2] = 32'h1234_5678; hot_addr[3] = 32'hA5A5_5A5A;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every opcode, busy cache, out-of-range port, matches
    queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'd0, 1'b0));
    queue_word(make_word(OP_REQ, 7, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
    queue_word(make_word(OP_REQ, 0, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0));
    queue_word(make_word(OP_REQ, 6, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0));
    queue_word(make_word(OP_REQ, 3, 32'h0, 1'b1, 16'd0, 1'b0));
    queue_word(make_word(OP_REQ, 3, 32'h1234_5678, 1'b1, 16'd0, 1'b0));
    queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'd0, 1'b1));
    queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'd5, 1'b0));
    queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'd5, 1'b0));
    queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'hFFFF, 1'b1));
    queue_word(make_word(OP_RDN, 0, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0));
    queue_word(make_word(OP_WRDN, 0, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0));
    queue_word(make_word(OP_RDN, 0, 32'h5555_5555, 1'b0, 16'd0, 1'b0));
    queue_word(make_word(OP_REQ, 2, 32'h1, 1'b0, 16'd0, 1'b0));
    for (int i = 0; i < 6; i++)
      queue_word(make_word(OP_TICK, 0, 32'd0, 1'b0, 16'd1, 1'b1));
    while (pending_words.size() != 0) @(posedge clk);

    // pause the sender until the block has drained
    hold_for_drain = 1'b1;
    repeat (3) @(posedge clk);
    while (expected_q.size() != 0 || busy || start) @(posedge clk);
    hold_for_drain = 1'b0;

    // random: mostly requests on a few hot addresses plus ticks, some noise
    for (int n = 0; n < 200; n++) begin
      op = $urandom_range(0, 9);
      if (op < 4) begin
        w = make_word(OP_REQ, $urandom_range(0, 7),
                      ($urandom_range(0, 3) == 0) ? $urandom() : hot_addr[$urandom_range(0, 3)],
                      $urandom_range(0, 5) != 0, 16'($urandom()), 1'($urandom()));
      end else if (op < 8) begin
        w = make_word(OP_TICK, $urandom(), $urandom(), 1'($urandom()),
                      ($urandom_range(0, 5) == 0) ? 16'd0 :
                      ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 4)),
                      1'($urandom()));
      end else begin
        w = make_word(op == 8 ? OP_RDN : OP_WRDN, $urandom(),
                      ($urandom_range(0, 4) == 0) ? $urandom() : hot_addr[$urandom_range(0, 3)],
                      1'($urandom()), 16'($urandom()), 1'($urandom()));
      end
      queue_word(w);
      if (n == 100) begin
        while (pending_words.size() != 0) @(posedge clk);
        hold_for_drain = 1'b1;
        repeat (3) @(posedge clk);
        while (expected_q.size() != 0 || busy || start) @(posedge clk);
        hold_for_drain = 1'b0;
      end
    end
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d words and %0d results: requests, ticks, memory done events",
             words_sent, results_seen);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
